// ----- rtl/core/ppr_pkg.sv -----
// shared types and constants of the pulse peak rate detector
package ppr_pkg;

    localparam int MARGIN_W = 12;
    localparam int TPM_W    = 16;
    localparam int WIN_W    = 8;
    localparam int VALUE_W  = 16;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd50;
    localparam logic [TPM_W-1:0]    TPM_RESET    = 16'd6000;
    localparam logic [WIN_W-1:0]    WIN_RESET    = 8'd1;
    localparam logic [WIN_W-1:0]    SEC_MAX      = 8'hFF;

    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SECOND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INTERVAL = 2'd2;

    localparam logic REPORT_MAX  = 1'b0;
    localparam logic REPORT_RATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

    typedef enum logic [3:0] {
        PH_MAX   = 4'b0001,
        PH_SLOPE = 4'b0010,
        PH_RISE  = 4'b0100,
        PH_FALL  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ppr_div_stat_t;

endpackage

// ----- rtl/core/ppr_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module ppr_div #(
    parameter int TICK_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ppr_pkg::TPM_W-1:0]  dividend,
    input  logic [TICK_BITS-1:0]       divisor,
    output ppr_pkg::ppr_div_stat_t     stat,
    output logic [ppr_pkg::TPM_W-1:0]  quotient
);
    import ppr_pkg::*;

    localparam int STEPS = TPM_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [TICK_BITS-1:0]  rem_reg, rem_next;
    logic [TICK_BITS-1:0]  dvs_reg, dvs_next;
    logic [TPM_W-1:0]      quo_reg, quo_next;
    logic [TICK_BITS:0]    trial;

    // quo_reg shifts the dividend out at the top and the quotient in at the bottom
    assign trial = {rem_reg, quo_reg[TPM_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = TICK_BITS'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[TPM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[TICK_BITS-1:0];
                quo_next = {quo_reg[TPM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- rtl/core/pulse_peak_rate_detector_top.sv -----
// top level of the pulse peak rate detector
//
// Input beats on s_*: tuser carries the kind (sample, one-second tick,
// interval tick), tdata the converter sample. Output beats on m_*: tuser says
// maximum (0) or heart rate (1), tdata holds the 16-bit value.
// The cfg port writes peak margin, ticks per minute or window seconds, one per
// write as cfg_index selects; write only while no result is outstanding.
// Each beat is handled in the cycle it is accepted. A maximum report is pushed
// into the output register (or the skid entry) when the sample that ends the
// window is accepted. A rate report goes through the bit-serial divider, one
// quotient bit per cycle, and its quotient is pushed as it lands; s_tready stays
// low while the divider runs. A zero interval reports 0 without the divider.
// Results sit in an output register backed by one skid entry, so input beats
// keep flowing while a result waits; s_tready drops once the skid entry is
// full too or while the divider runs; no result is lost while m_tready is low.
// Reset (aresetn low, synchronous) returns to the find-maximum phase with
// both timers stopped, clears the maximum and loads the register defaults.
module pulse_peak_rate_detector_top #(
    parameter int SAMPLE_BITS = 12,
    parameter int TICK_BITS   = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
    input  logic [ppr_pkg::KIND_W-1:0]          s_tuser,  // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ppr_pkg::VALUE_W-1:0]         m_tdata,  // report_value
    output logic                                m_tuser,  // report_kind
    input  logic                                cfg_we,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppr_pkg::TPM_W-1:0]           cfg_wdata
);
    import ppr_pkg::*;

    localparam int SUM_W = ((SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W) + 1;

    logic [MARGIN_W-1:0]    margin_reg;
    logic [TPM_W-1:0]       tpm_reg;
    logic [WIN_W-1:0]       win_reg;

    phase_t                 phase_reg, phase_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                   win_run_reg, win_run_next;
    logic [WIN_W-1:0]       sec_reg, sec_next;
    logic                   int_run_reg, int_run_next;
    logic [TICK_BITS-1:0]   ticks_reg, ticks_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic                   hold_kind_reg, hold_kind_next;
    logic [VALUE_W-1:0]     hold_value_reg, hold_value_next;

    logic                   accept;
    logic                   pop;
    logic [SAMPLE_BITS-1:0] smp;
    logic                   push_valid;
    logic                   push_kind;
    logic [VALUE_W-1:0]     push_value;
    logic                   div_start;
    logic                   peak;
    ppr_div_stat_t          div_stat;
    logic [TPM_W-1:0]       div_quo;

    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign s_tready = !div_stat.busy && !hold_valid_reg;
    assign smp      = s_tdata[SAMPLE_BITS-1:0];

    assign peak = (smp < prev_reg)
               && ((SUM_W'(prev_reg) + SUM_W'(margin_reg)) >= SUM_W'(max_reg));

    always_comb begin
        logic [SAMPLE_BITS-1:0] new_max;
        phase_next   = phase_reg;
        max_next     = max_reg;
        prev_next    = prev_reg;
        win_run_next = win_run_reg;
        sec_next     = sec_reg;
        int_run_next = int_run_reg;
        ticks_next   = ticks_reg;
        push_valid   = 1'b0;
        push_kind    = REPORT_MAX;
        push_value   = '0;
        div_start    = 1'b0;
        new_max      = (smp > max_reg) ? smp : max_reg;

        if (accept) begin
            case (s_tuser)
                KIND_SAMPLE: begin
                    case (phase_reg)
                        PH_MAX: begin
                            if (!win_run_reg) begin
                                win_run_next = 1'b1;
                            end else begin
                                max_next = new_max;
                                if (sec_reg >= win_reg) begin
                                    phase_next   = PH_SLOPE;
                                    prev_next    = smp;
                                    win_run_next = 1'b0;
                                    sec_next     = '0;
                                    push_valid   = 1'b1;
                                    push_kind    = REPORT_MAX;
                                    push_value   = VALUE_W'(new_max);
                                end
                            end
                        end
                        PH_SLOPE: begin
                            if (smp > prev_reg) begin
                                phase_next = PH_RISE;
                            end else if (smp < prev_reg) begin
                                phase_next = PH_FALL;
                            end
                            prev_next = smp;
                        end
                        PH_RISE: begin
                            if (peak) begin
                                if (int_run_reg) begin
                                    int_run_next = 1'b0;
                                    ticks_next   = '0;
                                    phase_next   = PH_MAX;
                                    if (ticks_reg == '0) begin
                                        push_valid = 1'b1;
                                        push_kind  = REPORT_RATE;
                                        push_value = '0;
                                    end else begin
                                        div_start = 1'b1;
                                    end
                                end else begin
                                    int_run_next = 1'b1;
                                    phase_next   = PH_FALL;
                                end
                            end
                            prev_next = smp;
                        end
                        default: begin
                            if (smp > prev_reg) begin
                                phase_next = PH_RISE;
                            end
                            prev_next = smp;
                        end
                    endcase
                end
                KIND_SECOND: begin
                    if (win_run_reg && sec_reg != SEC_MAX) begin
                        sec_next = sec_reg + 1'b1;
                    end
                end
                KIND_INTERVAL: begin
                    if (int_run_reg) begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // a beat taken while the quotient lands is in the find-maximum phase
        // with the window stopped, so it never reports on its own
        if (div_stat.done) begin
            push_valid = 1'b1;
            push_kind  = REPORT_RATE;
            push_value = div_quo;
        end
    end

    // output register with one skid entry behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_value_next = hold_value_reg;
        if (!out_valid_reg || pop) begin
            if (hold_valid_reg) begin
                out_valid_next  = 1'b1;
                out_kind_next   = hold_kind_reg;
                out_value_next  = hold_value_reg;
                hold_valid_next = push_valid;
                hold_kind_next  = push_kind;
                hold_value_next = push_value;
            end else begin
                out_valid_next = push_valid;
                out_kind_next  = push_kind;
                out_value_next = push_value;
            end
        end else if (push_valid) begin
            hold_valid_next = 1'b1;
            hold_kind_next  = push_kind;
            hold_value_next = push_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg     <= MARGIN_RESET;
            tpm_reg        <= TPM_RESET;
            win_reg        <= WIN_RESET;
            phase_reg      <= PH_MAX;
            max_reg        <= '0;
            prev_reg       <= '0;
            win_run_reg    <= 1'b0;
            sec_reg        <= '0;
            int_run_reg    <= 1'b0;
            ticks_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MARGIN: margin_reg <= cfg_wdata[MARGIN_W-1:0];
                    CFG_TPM:    tpm_reg    <= cfg_wdata;
                    CFG_WINDOW: win_reg    <= cfg_wdata[WIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            phase_reg      <= phase_next;
            max_reg        <= max_next;
            prev_reg       <= prev_next;
            win_run_reg    <= win_run_next;
            sec_reg        <= sec_next;
            int_run_reg    <= int_run_next;
            ticks_reg      <= ticks_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
        out_kind_reg   <= out_kind_next;
        out_value_reg  <= out_value_next;
        hold_kind_reg  <= hold_kind_next;
        hold_value_reg <= hold_value_next;
    end

    ppr_div #(
        .TICK_BITS (TICK_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tpm_reg),
        .divisor  (ticks_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_kind_reg;

endmodule
